// File: rtl/rqtrp_pkg.sv
// Package for the ranked point store with rectangle query.
// Holds widths, operation codes and the stored point type; no dependencies.
`timescale 1ns / 1ps
package rqtrp_pkg;
	localparam int POINTS_DEF = 1024;
	localparam int MAX_REPORT_DEF = 64;
	localparam int IN_W = 248;
	localparam int OUT_W = 112;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic signed [7:0] id;
		logic signed [31:0] rank;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;
endpackage

// File: rtl/rqtrp_cell.sv
// One cell of the sorted point chain: holds one point and its valid flag.
// Depends on rqtrp_pkg.
`timescale 1ns / 1ps
module rqtrp_cell import rqtrp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   clr,
	input  logic   ins,
	input  logic   rot,
	input  point_t new_pt,
	input  point_t prev_pt,
	input  logic   prev_valid,
	input  logic   prev_shift,
	input  point_t rot_pt,
	output logic   shift,
	output point_t pt_q,
	output logic   valid_q
);
	assign shift = valid_q && (pt_q.rank > new_pt.rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			if (prev_shift) begin
				valid_q <= prev_valid;
			end else if (shift || (!valid_q && prev_valid)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rot) begin
			pt_q <= rot_pt;
		end else if (ins) begin
			if (prev_shift) begin
				pt_q <= prev_pt;
			end else if (shift || (!valid_q && prev_valid)) begin
				pt_q <= new_pt;
			end
		end
	end
endmodule

// File: rtl/rect_query_top_rank_points.sv
// Top level: stream ports, command sequencer and the chain of point cells.
// Depends on rqtrp_pkg and rqtrp_cell.
//
// Usage: one input channel (s_axis_*) carries commands: clear, insert, query.
// The output channel (m_axis_*) carries query results; tlast marks the last.
// The store is a chain of POINTS cells in ascending rank order. On an insert
// every cell compares its rank and the ones after the insertion place shift
// one step down. A full store drops the insert.
// A clear empties the store.
// A query rotates the chain once around, cell 0 feeding the last cell, and
// tests cell 0 at each rotation step; matches leave in rank order, up to
// max_count (saturated to MAX_REPORT). With no match one item with found
// low is sent.
// A result waits in an output register; while the receiver stalls the
// rotation holds. s_axis_tready is low while a query runs.
// After reset the store is empty.
`timescale 1ns / 1ps
module rect_query_top_rank_points import rqtrp_pkg::*; #(
	parameter int POINTS = POINTS_DEF,
	parameter int MAX_REPORT = MAX_REPORT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation, point_id, point_rank, point_x, point_y, low_x, low_y,
	// high_x, high_y, max_count, zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// found, out_id, out_rank, out_x, out_y, match_index, zero pad
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast
);
	localparam int CW = $clog2(POINTS + 1);
	localparam int NW = $clog2(MAX_REPORT + 1);

	logic [1:0] op;
	point_t new_pt;
	assign op = s_axis_tdata[1:0];
	assign new_pt.id = s_axis_tdata[9:2];
	assign new_pt.rank = s_axis_tdata[41:10];
	assign new_pt.x = s_axis_tdata[73:42];
	assign new_pt.y = s_axis_tdata[105:74];

	logic busy_q;
	logic [CW-1:0] cnt_q, step_q;
	logic [NW-1:0] n_q, lim_q;
	logic signed [31:0] lx_q, ly_q, hx_q, hy_q;
	logic mv_q;

	logic acc, clr, ins, rot, fire_end;
	point_t pt [POINTS];
	logic vld [POINTS];
	logic sh [POINTS];

	assign s_axis_tready = !busy_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign clr = acc && (op == OP_CLEAR);
	assign ins = acc && (op == OP_INSERT) && (cnt_q != CW'(POINTS));
	assign rot = busy_q && (!mv_q || m_axis_tready) && (step_q != CW'(POINTS));
	assign fire_end = busy_q && (step_q == CW'(POINTS)) && (!mv_q || m_axis_tready);

	genvar g;
	generate
		for (g = 0; g < POINTS; g++) begin : g_cell
			rqtrp_cell u_cell (
				.clk(clk), .arst_n(arst_n), .clr(clr), .ins(ins), .rot(rot),
				.new_pt(new_pt),
				.prev_pt(g == 0 ? new_pt : pt[(g == 0) ? 0 : g-1]),
				.prev_valid(g == 0 ? 1'b1 : vld[(g == 0) ? 0 : g-1]),
				.prev_shift(g == 0 ? 1'b0 : sh[(g == 0) ? 0 : g-1]),
				.rot_pt(pt[(g + 1) % POINTS]),
				.shift(sh[g]), .pt_q(pt[g]), .valid_q(vld[g])
			);
		end
	endgenerate

	logic hit;
	assign hit = (step_q < cnt_q) && (n_q < lim_q) && (pt[0].x >= lx_q) &&
		(pt[0].x <= hx_q) && (pt[0].y >= ly_q) && (pt[0].y <= hy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			step_q <= '0;
			n_q <= '0;
			lim_q <= '0;
		end else begin
			if (clr) cnt_q <= '0;
			if (ins) cnt_q <= cnt_q + 1'b1;
			if (acc && op == OP_QUERY) begin
				busy_q <= 1'b1;
				step_q <= '0;
				n_q <= '0;
				lim_q <= (s_axis_tdata[240:234] > 7'(MAX_REPORT)) ? NW'(MAX_REPORT) :
					NW'(s_axis_tdata[240:234]);
			end
			if (rot) begin
				step_q <= step_q + 1'b1;
				if (hit) begin
					n_q <= n_q + 1'b1;
				end
			end else if (fire_end) begin
				busy_q <= 1'b0;
			end
		end
	end

	logic [OUT_W-1:0] hold_q;
	logic pend_q;
	always_ff @(posedge clk) begin
		if (acc && op == OP_QUERY) begin
			lx_q <= s_axis_tdata[137:106];
			ly_q <= s_axis_tdata[169:138];
			hx_q <= s_axis_tdata[201:170];
			hy_q <= s_axis_tdata[233:202];
		end
	end

	// Hold one match back so that tlast can be decided on the next hit or at end.
	logic [OUT_W-1:0] cur;
	assign cur = {1'b0, 6'(n_q), pt[0].y, pt[0].x, pt[0].rank, pt[0].id, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (acc && op == OP_QUERY) begin
			pend_q <= 1'b0;
		end else if (rot && hit) begin
			pend_q <= 1'b1;
		end
	end

	logic [OUT_W-1:0] dat_q;
	logic last_q;
	always_ff @(posedge clk) begin
		if (rot && hit) begin
			hold_q <= cur;
		end
		if (rot && hit && pend_q) begin
			dat_q <= hold_q;
			last_q <= 1'b0;
		end else if (fire_end) begin
			dat_q <= pend_q ? hold_q : '0;
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else begin
			if (mv_q && m_axis_tready) mv_q <= 1'b0;
			if ((rot && hit && pend_q) || fire_end) mv_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = mv_q;
	assign m_axis_tdata = dat_q;
	assign m_axis_tlast = last_q;
endmodule

// File: sim/tb_top.sv
// Self-checking testbench for rect_query_top_rank_points: directed table, then random traffic.
// Depends on rqtrp_pkg and the top level; a rank-ordered point store model predicts each query.
`timescale 1ns / 1ps
module tb_top;
	import rqtrp_pkg::*;

	localparam int DEPTH = POINTS_DEF;
	localparam int REPORT = MAX_REPORT_DEF;
	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;

	typedef struct {
		op_t op;
		point_t p;
		logic signed [31:0] lx, ly, hx, hy;
		logic [6:0] mc;
		bit none_exp;
	} cmd_t;

	typedef struct {
		logic found;
		logic signed [7:0] id;
		logic signed [31:0] rank, x, y;
		logic [5:0] idx;
		logic last;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// operation, point_id, point_rank, point_x, point_y, low_x, low_y,
	// high_x, high_y, max_count, zero pad
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// found, out_id, out_rank, out_x, out_y, match_index, zero pad
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	point_t store_pts [DEPTH];
	int store_cnt = 0;
	match_t pending_matches [$];
	cmd_t table_rows [$];
	int errors = 0;
	int items_sent = 0;
	int queries_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int rx_phase = 0;

	always #1 clk = ~clk;

	rect_query_top_rank_points i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	function automatic logic [IN_W-1:0] pack_cmd(cmd_t c);
		logic [IN_W-1:0] v;
		v = '0;
		v[240:0] = {c.mc, c.hy, c.hx, c.ly, c.lx, c.p.y, c.p.x, c.p.rank, c.p.id, c.op};
		return v;
	endfunction

	function automatic match_t no_match();
		match_t m;
		m = '{found: 1'b0, id: '0, rank: '0, x: '0, y: '0, idx: '0, last: 1'b1};
		return m;
	endfunction

	// advance the store model by one command, queue any query output
	task automatic apply_store_cmd(cmd_t c);
		int pos;
		int lim;
		int n;
		match_t m;
		case (c.op)
			OP_CLEAR: store_cnt = 0;
			OP_INSERT: if (store_cnt < DEPTH) begin
				pos = store_cnt;
				while (pos > 0 && store_pts[pos-1].rank > c.p.rank) begin
					store_pts[pos] = store_pts[pos-1];
					pos--;
				end
				store_pts[pos] = c.p;
				store_cnt++;
			end
			OP_QUERY: begin
				lim = (c.mc > REPORT) ? REPORT : c.mc;
				n = 0;
				for (int i = 0; i < store_cnt && n < lim; i++) begin
					if (c.lx <= store_pts[i].x && store_pts[i].x <= c.hx &&
							c.ly <= store_pts[i].y && store_pts[i].y <= c.hy) begin
						m.found = 1'b1;
						m.id = store_pts[i].id;
						m.rank = store_pts[i].rank;
						m.x = store_pts[i].x;
						m.y = store_pts[i].y;
						m.idx = n[5:0];
						m.last = 1'b0;
						pending_matches.push_back(m);
						n++;
					end
				end
				if (n == 0)
					pending_matches.push_back(no_match());
				else
					pending_matches[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic send_cmd(cmd_t c);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_cmd(c);
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		items_sent++;
		if (c.op == OP_QUERY)
			queries_sent++;
		if (c.none_exp)
			pending_matches.push_back(no_match());
		else
			apply_store_cmd(c);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_matches.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] rnd_coord();
		logic signed [31:0] v;
		if ($urandom_range(0, 5) == 0)
			return $urandom;
		v = $urandom_range(0, 40);
		v = (v - 20) <<< 16;
		return v + $urandom_range(0, 3) * 32'sh4000;
	endfunction

	function automatic cmd_t rnd_cmd(int kind);
		cmd_t c;
		logic signed [31:0] span;
		c.op = op_t'(kind);
		c.p.id = 8'($urandom);
		c.p.rank = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15) - 8;
		c.p.x = rnd_coord();
		c.p.y = rnd_coord();
		c.mc = 7'($urandom);
		c.lx = $urandom;
		c.ly = $urandom;
		c.hx = $urandom;
		c.hy = $urandom;
		c.none_exp = 0;
		if (kind == OP_QUERY) begin
			if ($urandom_range(0, 9) == 0) begin
				c.lx = MINV; c.ly = MINV; c.hx = MAXV; c.hy = MAXV;
			end else if ($urandom_range(0, 7) != 0) begin
				c.lx = rnd_coord();
				c.ly = rnd_coord();
				span = $urandom_range(0, 30);
				c.hx = c.lx + (span <<< 16);
				span = $urandom_range(0, 30);
				c.hy = c.ly + (span <<< 16);
				if (c.hx < c.lx) c.hx = MAXV;
				if (c.hy < c.ly) c.hy = MAXV;
			end
			if ($urandom_range(0, 4) != 0)
				c.mc = 7'($urandom_range(1, REPORT));
		end
		return c;
	endfunction

	function automatic cmd_t row(op_t op, logic signed [7:0] id, logic signed [31:0] rk,
			logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] lx,
			logic signed [31:0] ly, logic signed [31:0] hx, logic signed [31:0] hy,
			logic [6:0] mc, bit none_exp);
		cmd_t c;
		c.op = op; c.p.id = id; c.p.rank = rk; c.p.x = px; c.p.y = py;
		c.lx = lx; c.ly = ly; c.hx = hx; c.hy = hy; c.mc = mc; c.none_exp = none_exp;
		return c;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result side: compare each item, pace tready, watch for a stall
	always @(posedge clk) begin
		match_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (pending_matches.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, m_axis_tdata);
					errors++;
				end else begin
					e = pending_matches.pop_front();
					check_field("found", e.found, m_axis_tdata[0]);
					check_field("out_id", {24'd0, e.id}, m_axis_tdata[8:1]);
					check_field("out_rank", e.rank, m_axis_tdata[40:9]);
					check_field("out_x", e.x, m_axis_tdata[72:41]);
					check_field("out_y", e.y, m_axis_tdata[104:73]);
					check_field("match_index", e.idx, m_axis_tdata[110:105]);
					check_field("last", e.last, m_axis_tlast);
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
			rx_phase = (rx_phase + 1) % 96;
			if (rx_phase < 24)
				m_axis_tready <= 1'b1;
			else if (rx_phase < 28)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		int kind;
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 64, 1));
		table_rows.push_back(row(OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, 7'h7f, 0));
		table_rows.push_back(row(OP_INSERT, -128, MINV, MINV, MINV, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(row(OP_INSERT, 127, MAXV, MAXV, MAXV, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(row(OP_INSERT, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(row(OP_INSERT, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(row(OP_INSERT, -1, -5, 100, -100, 0, 0, 0, 0, 0, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 64, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 0, 1));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 127, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 1, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, 1, MINV, 0, MAXV, 64, 1));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, 1, MAXV, 0, 64, 1));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 64, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV, 65, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MINV, MINV, 64, 0));
		table_rows.push_back(row(OP_CLEAR, -1, -1, -1, -1, -1, -1, -1, -1, 7'h7f, 0));
		table_rows.push_back(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 64, 1));
		foreach (table_rows[i])
			send_cmd(table_rows[i]);

		for (int n = 0; n < 150; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) kind = OP_CLEAR;
			else if (pick < 6) kind = OP_NONE;
			else if (pick < 60) kind = OP_INSERT;
			else kind = OP_QUERY;
			send_cmd(rnd_cmd(kind));
			if (n == 75)
				drain();
		end

		// finish with a full-range query and a few random ones
		send_cmd(row(OP_QUERY, 0, 0, 0, 0, MINV, MINV, MAXV, MAXV, 64, 0));
		for (int n = 0; n < 4; n++)
			send_cmd(rnd_cmd(OP_QUERY));
		s_axis_tvalid <= 1'b0;

		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 20) @(posedge clk);
		if (pending_matches.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_matches.size());
			errors++;
		end
		$display("Sent %0d commands (%0d queries), checked %0d result items, %0d errors.",
			items_sent, queries_sent, results_seen, errors);
		$display("Covered empty store, zero and saturated limits, empty rectangles, equal ranks.");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
